// File: sv/spmv_pkg.sv
// ----------------------------------------------------------------------------
// spmv_pkg: shared types and constants of the sparse matrix-vector multiplier
// Request codes, queue entry formats and the row clamp used by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package spmv_pkg;

    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int ROW_W   = 16;
    localparam int ACC_W   = 64;

    localparam int VECTOR_DEPTH_DEF = 1024;
    localparam logic [20:0] ROW_LIMIT = 21'd65536;

    localparam int OP_QUEUE_DEPTH  = 4;
    localparam int OUT_QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_NONZERO = 2'd1,
        REQ_EMPTY   = 2'd2,
        REQ_UNUSED  = 2'd3
    } t_req;

    // Work handed from the front to the back.
    typedef struct packed {
        logic                    is_empty;
        logic                    row_end;
        logic [ROW_W-1:0]        row;
        logic signed [ACC_W-1:0] prod;
    } t_op;

    typedef struct packed {
        logic [ROW_W-1:0]          row;
        logic signed [VALUE_W-1:0] sum;
        logic                      sat;
    } t_result;

    function automatic logic [ROW_W-1:0] clamp_row(input logic [ROW_W-1:0] r);
        logic [ROW_W-1:0] v;
        if ({5'b0, r} >= ROW_LIMIT) begin
            v = ROW_W'(ROW_LIMIT - 21'd1);
        end else begin
            v = r;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: sv/spmv_fifo.sv
// ----------------------------------------------------------------------------
// spmv_fifo: small register queue
// Circular buffer with an occupancy count; the head entry is shown directly.
// ----------------------------------------------------------------------------
`default_nettype none

module spmv_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    input  wire logic                       i_pop,
    output logic      [WIDTH-1:0]           o_data,
    output logic                            o_empty,
    output logic      [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_pop;

    assign w_pop = i_pop & (r_count != '0);

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_count <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

`default_nettype wire

// File: sv/spmv_front.sv
// ----------------------------------------------------------------------------
// spmv_front: item intake, vector store and multiplier
// Loads write the vector store; nonzeros read it and form the Q32.32 product.
// ----------------------------------------------------------------------------
`default_nettype none

module spmv_front #(
    parameter int VECTOR_DEPTH = spmv_pkg::VECTOR_DEPTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_push,
    input  wire logic [1:0]                             i_req_type,
    input  wire logic [spmv_pkg::INDEX_W-1:0]           i_index,
    input  wire logic [spmv_pkg::VALUE_W-1:0]           i_value,
    input  wire logic [spmv_pkg::ROW_W-1:0]             i_row_index,
    input  wire logic                                   i_row_end,
    output logic                                        o_full,
    input  wire logic [$clog2(spmv_pkg::OP_QUEUE_DEPTH+1)-1:0] i_op_count,
    output logic                                        o_op_push,
    output spmv_pkg::t_op                               o_op
);

    import spmv_pkg::*;

    // Only the first 1024 positions are reachable through a 10-bit index.
    localparam int MEM_DEPTH = (VECTOR_DEPTH < (1 << INDEX_W)) ? VECTOR_DEPTH
                                                               : (1 << INDEX_W);
    localparam int ADDR_W = $clog2(MEM_DEPTH);
    localparam logic [16:0] DEPTH_LIM = 17'(VECTOR_DEPTH);
    localparam int CNT_W = $clog2(OP_QUEUE_DEPTH + 1);

    logic [VALUE_W-1:0] r_mem [MEM_DEPTH];
    logic [VALUE_W-1:0] r_rd;

    logic               w_accept;
    logic               w_in_range;
    logic               w_is_op;
    logic               w_write;
    logic [ADDR_W-1:0]  w_addr;
    t_req               w_req;
    logic [CNT_W:0]     w_in_flight;

    logic               r_s1_valid;
    logic               r_s1_empty;
    logic               r_s1_end;
    logic               r_s1_in_range;
    logic [ROW_W-1:0]   r_s1_row;
    logic signed [VALUE_W-1:0] r_s1_value;

    logic               r_s2_valid;
    t_op                r_s2_op;

    logic signed [VALUE_W-1:0] w_xv;

    assign w_req = t_req'(i_req_type);
    assign w_in_range = ({7'b0, i_index} < DEPTH_LIM);
    assign w_addr = i_index[ADDR_W-1:0];

    // Space in the queue is reserved for every op still in the two stages.
    assign w_in_flight = {1'b0, i_op_count} + (CNT_W+1)'(r_s1_valid)
                       + (CNT_W+1)'(r_s2_valid);
    assign o_full = (w_in_flight >= (CNT_W+1)'(OP_QUEUE_DEPTH));
    assign w_accept = i_push & ~o_full;

    always_comb begin
        w_is_op = 1'b0;
        w_write = 1'b0;
        case (w_req)
            REQ_LOAD:    w_write = w_accept & w_in_range;
            REQ_NONZERO: w_is_op = w_accept;
            REQ_EMPTY:   w_is_op = w_accept;
            default:     w_is_op = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_mem[w_addr] <= i_value;
        end
        r_rd <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_is_op;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_empty <= (w_req == REQ_EMPTY);
        r_s1_end <= i_row_end;
        r_s1_in_range <= w_in_range;
        r_s1_row <= clamp_row(i_row_index);
        r_s1_value <= i_value;
    end

    assign w_xv = r_s1_in_range ? r_rd : '0;

    always_ff @(posedge i_clk) begin
        r_s2_op.is_empty <= r_s1_empty;
        r_s2_op.row_end <= r_s1_end;
        r_s2_op.row <= r_s1_row;
        r_s2_op.prod <= r_s1_value * w_xv;
    end

    assign o_op_push = r_s2_valid;
    assign o_op = r_s2_op;

endmodule

`default_nettype wire

// File: sv/spmv_back.sv
// ----------------------------------------------------------------------------
// spmv_back: row accumulator and result formatting
// Saturating Q32.32 accumulation, then conversion of a finished row to Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module spmv_back (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire spmv_pkg::t_op                               i_op,
    input  wire logic                                        i_op_empty,
    output logic                                             o_op_pop,
    input  wire logic [$clog2(spmv_pkg::OUT_QUEUE_DEPTH+1)-1:0] i_out_count,
    output logic                                             o_res_push,
    output spmv_pkg::t_result                                o_res
);

    import spmv_pkg::*;

    localparam int CNT_W = $clog2(OUT_QUEUE_DEPTH + 1);
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic                    r_ovf, n_ovf;

    logic                    r_fin_valid, n_fin_valid;
    logic [ROW_W-1:0]        r_fin_row;
    logic signed [ACC_W-1:0] r_fin_acc, n_fin_acc;
    logic                    r_fin_ovf, n_fin_ovf;

    logic signed [ACC_W-1:0] w_sum;
    logic signed [ACC_W-1:0] w_sat_sum;
    logic                    w_add_ovf;
    logic [CNT_W:0]          w_pending;
    logic                    w_range_sat;

    assign w_pending = {1'b0, i_out_count} + (CNT_W+1)'(r_fin_valid);
    assign o_op_pop = ~i_op_empty & (w_pending < (CNT_W+1)'(OUT_QUEUE_DEPTH));

    assign w_sum = r_acc + i_op.prod;
    assign w_add_ovf = (r_acc[ACC_W-1] == i_op.prod[ACC_W-1])
                     & (w_sum[ACC_W-1] != r_acc[ACC_W-1]);
    assign w_sat_sum = w_add_ovf ? (r_acc[ACC_W-1] ? ACC_MIN : ACC_MAX) : w_sum;

    always_comb begin
        n_acc = r_acc;
        n_ovf = r_ovf;
        n_fin_valid = 1'b0;
        n_fin_acc = w_sat_sum;
        n_fin_ovf = r_ovf | w_add_ovf;
        if (o_op_pop) begin
            if (i_op.is_empty) begin
                // An empty row reports zero and leaves any open row alone.
                n_fin_valid = 1'b1;
                n_fin_acc = '0;
                n_fin_ovf = 1'b0;
            end else if (i_op.row_end) begin
                n_fin_valid = 1'b1;
                n_acc = '0;
                n_ovf = 1'b0;
            end else begin
                n_acc = w_sat_sum;
                n_ovf = r_ovf | w_add_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
            r_fin_valid <= 1'b0;
        end else begin
            r_acc <= n_acc;
            r_ovf <= n_ovf;
            r_fin_valid <= n_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_fin_valid) begin
            r_fin_row <= i_op.row;
            r_fin_acc <= n_fin_acc;
            r_fin_ovf <= n_fin_ovf;
        end
    end

    // The Q16.16 value is bits 47:16; it fits only if bits 63:47 agree.
    assign w_range_sat = (r_fin_acc[ACC_W-1:47] != {17{r_fin_acc[ACC_W-1]}});

    always_comb begin
        o_res.row = r_fin_row;
        o_res.sat = r_fin_ovf | w_range_sat;
        if (w_range_sat) begin
            o_res.sum = r_fin_acc[ACC_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                           : {1'b0, {(VALUE_W-1){1'b1}}};
        end else begin
            o_res.sum = r_fin_acc[47:16];
        end
    end

    assign o_res_push = r_fin_valid;

endmodule

`default_nettype wire

// File: sv/csr_sparse_matrix_vector_multiply_top.sv
// Throughput: one item per cycle while o_full is low, one multiply-accumulate
// per cycle while the output queue has room, set by the single 32x32
// multiplier and the 64-bit accumulator loop in the back part.
// Reset: synchronous, active low; clears the accumulator, overflow flag and
// queues. The vector store is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply_top: streaming sparse y = A*x in Q16.16
// Front part stores the vector and multiplies, back part accumulates rows.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_sparse_matrix_vector_multiply_top #(
    parameter int VECTOR_DEPTH = spmv_pkg::VECTOR_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    output logic                               o_full,
    input  wire logic [1:0]                    i_req_type,
    input  wire logic [spmv_pkg::INDEX_W-1:0]  i_index,
    input  wire logic [spmv_pkg::VALUE_W-1:0]  i_value,
    input  wire logic [spmv_pkg::ROW_W-1:0]    i_row_index,
    input  wire logic                          i_row_end,
    output logic                               o_empty,
    input  wire logic                          i_pop,
    output logic [spmv_pkg::ROW_W-1:0]         o_out_row,
    output logic [spmv_pkg::VALUE_W-1:0]       o_row_sum,
    output logic                               o_saturated
);

    import spmv_pkg::*;

    localparam int OP_CNT_W  = $clog2(OP_QUEUE_DEPTH + 1);
    localparam int OUT_CNT_W = $clog2(OUT_QUEUE_DEPTH + 1);

    t_op                  w_op_in;
    t_op                  w_op_out;
    logic                 w_op_push;
    logic                 w_op_pop;
    logic                 w_op_empty;
    logic [OP_CNT_W-1:0]  w_op_count;

    t_result              w_res_in;
    t_result              w_res_out;
    logic                 w_res_push;
    logic [OUT_CNT_W-1:0] w_out_count;

    spmv_front #(
        .VECTOR_DEPTH (VECTOR_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_req_type  (i_req_type),
        .i_index     (i_index),
        .i_value     (i_value),
        .i_row_index (i_row_index),
        .i_row_end   (i_row_end),
        .o_full      (o_full),
        .i_op_count  (w_op_count),
        .o_op_push   (w_op_push),
        .o_op        (w_op_in)
    );

    spmv_fifo #(
        .WIDTH ($bits(t_op)),
        .DEPTH (OP_QUEUE_DEPTH)
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_op_push),
        .i_data  (w_op_in),
        .i_pop   (w_op_pop),
        .o_data  (w_op_out),
        .o_empty (w_op_empty),
        .o_count (w_op_count)
    );

    spmv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op_out),
        .i_op_empty  (w_op_empty),
        .o_op_pop    (w_op_pop),
        .i_out_count (w_out_count),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    spmv_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .i_pop   (i_pop),
        .o_data  (w_res_out),
        .o_empty (o_empty),
        .o_count (w_out_count)
    );

    assign o_out_row   = w_res_out.row;
    assign o_row_sum   = w_res_out.sum;
    assign o_saturated = w_res_out.sat;

endmodule

`default_nettype wire
